// ===== rtl/core/dtl_pkg.sv =====
// Shared types and constants for the decision tree leaf lookup block.
`timescale 1ns / 1ps

package dtl_pkg;

  // Fixed field widths of the request and response channels
  localparam int unsigned FUNC_W     = 1;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned FIDX_W     = 8;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned TARGET_W   = 10;
  localparam int unsigned CHILD_W    = TARGET_W + 1;
  localparam int unsigned LEAF_BIT   = TARGET_W;
  localparam int unsigned LEAF_CNT_W = 11;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_NODE_WRITE  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FEATURE_LD  = 1'b1;

  typedef enum logic [1:0] {
    CMD_NODE,
    CMD_FEAT,
    CMD_WALK
  } cmd_kind_e;

  typedef enum logic [1:0] {
    WS_IDLE,
    WS_NODE,
    WS_FEAT
  } walk_state_e;

  // Classified command passed from front to back
  typedef struct packed {
    cmd_kind_e                  kind;
    logic                       store;
    logic [SLOT_W-1:0]          slot;
    logic [FIDX_W-1:0]          split_feature;
    logic signed [FIELD_W-1:0]  split_threshold;
    logic [CHILD_W-1:0]         left_child;
    logic [CHILD_W-1:0]         right_child;
    logic [FIDX_W-1:0]          feature_position;
    logic signed [FIELD_W-1:0]  feature_value;
  } cmd_t;

endpackage

// ===== rtl/core/dtl_if.sv =====
// Request and response channel interfaces of the decision tree leaf lookup block.
`timescale 1ns / 1ps

interface dtl_req_if;
  logic                                valid;
  logic                                ready;
  logic [dtl_pkg::FUNC_W-1:0]          func;
  logic [dtl_pkg::SLOT_W-1:0]          node_slot;
  logic [dtl_pkg::FIDX_W-1:0]          split_feature;
  logic signed [dtl_pkg::FIELD_W-1:0]  split_threshold;
  logic                                left_is_leaf;
  logic [dtl_pkg::TARGET_W-1:0]        left_target;
  logic                                right_is_leaf;
  logic [dtl_pkg::TARGET_W-1:0]        right_target;
  logic [dtl_pkg::FIDX_W-1:0]          feature_position;
  logic signed [dtl_pkg::FIELD_W-1:0]  feature_value;
  logic                                feature_last;

  modport source (
    output valid, func, node_slot, split_feature, split_threshold, left_is_leaf,
           left_target, right_is_leaf, right_target, feature_position,
           feature_value, feature_last,
    input  ready
  );

  modport sink (
    input  valid, func, node_slot, split_feature, split_threshold, left_is_leaf,
           left_target, right_is_leaf, right_target, feature_position,
           feature_value, feature_last,
    output ready
  );
endinterface

interface dtl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dtl_pkg::TARGET_W-1:0]  leaf_number;
  logic                          walk_error;

  modport source (
    output valid, leaf_number, walk_error,
    input  ready
  );

  modport sink (
    input  valid, leaf_number, walk_error,
    output ready
  );
endinterface

// ===== rtl/core/dtl_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module dtl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dtl_front.sv =====
// Front stage: accepts requests, classifies them and range checks the store slot.
`timescale 1ns / 1ps

module dtl_front #(
  parameter int unsigned MAX_NODES    = 1024,
  parameter int unsigned MAX_FEATURES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dtl_req_if.sink        req_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output dtl_pkg::cmd_t  cmd_o
);

  logic          valid_q;
  dtl_pkg::cmd_t cmd_q;
  dtl_pkg::cmd_t cmd_d;
  logic          accept;

  assign req_i.ready = !valid_q || cmd_ready_i;
  assign accept      = req_i.valid && req_i.ready;

  // Classify the request and check whether its slot exists
  always_comb begin
    cmd_d                  = '0;
    cmd_d.slot             = req_i.node_slot;
    cmd_d.split_feature    = req_i.split_feature;
    cmd_d.split_threshold  = req_i.split_threshold;
    cmd_d.left_child       = {req_i.left_is_leaf, req_i.left_target};
    cmd_d.right_child      = {req_i.right_is_leaf, req_i.right_target};
    cmd_d.feature_position = req_i.feature_position;
    cmd_d.feature_value    = req_i.feature_value;
    if (req_i.func == dtl_pkg::FUNC_NODE_WRITE) begin
      cmd_d.kind  = dtl_pkg::CMD_NODE;
      cmd_d.store = (int'(req_i.node_slot) < MAX_NODES);
    end else begin
      cmd_d.kind  = req_i.feature_last ? dtl_pkg::CMD_WALK : dtl_pkg::CMD_FEAT;
      cmd_d.store = (int'(req_i.feature_position) < MAX_FEATURES);
    end
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (cmd_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// ===== rtl/core/dtl_queue.sv =====
// Short command queue that decouples the front stage from the walk engine.
`timescale 1ns / 1ps

module dtl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dtl_pkg::cmd_t  in_cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dtl_pkg::cmd_t  out_cmd_o
);

  dtl_pkg::cmd_t                entries_q [dtl_pkg::QUEUE_DEPTH];
  logic [dtl_pkg::QPTR_W-1:0]   wr_ptr_q;
  logic [dtl_pkg::QPTR_W-1:0]   rd_ptr_q;
  logic [dtl_pkg::QCNT_W-1:0]   count_q;
  logic                         push;
  logic                         pop;

  assign in_ready_o  = (count_q != dtl_pkg::QCNT_W'(dtl_pkg::QUEUE_DEPTH));
  assign out_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_cmd_o   = entries_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule

// ===== rtl/core/dtl_back.sv =====
// Back end: stores node and feature entries and walks the tree for each vector.
`timescale 1ns / 1ps

module dtl_back #(
  parameter int unsigned MAX_NODES    = 1024,
  parameter int unsigned MAX_FEATURES = 256,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dtl_pkg::LEAF_CNT_W-1:0]    cfg_wdata_i,
  input  logic                              cmd_valid_i,
  output logic                              cmd_ready_o,
  input  dtl_pkg::cmd_t                     cmd_i,
  dtl_rsp_if.source                         rsp_o
);

  localparam int unsigned NA_W   = $clog2(MAX_NODES);
  localparam int unsigned FA_W   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned ST_W   = $clog2(MAX_NODES + 1);
  localparam int unsigned CW     = dtl_pkg::CHILD_W;
  localparam int unsigned NODE_W = dtl_pkg::FIDX_W + VALUE_WIDTH + 2 * CW;

  dtl_pkg::walk_state_e                state_q, state_d;
  logic [ST_W-1:0]                     steps_q, steps_d;
  logic [dtl_pkg::LEAF_CNT_W-1:0]      leaf_count_q;
  logic                                out_valid_q;
  logic [dtl_pkg::TARGET_W-1:0]        out_leaf_q;
  logic                                out_err_q;

  logic                                pop;
  logic                                out_set;
  logic [dtl_pkg::TARGET_W-1:0]        out_leaf_d;
  logic                                out_err_d;

  logic                                node_we;
  logic [NODE_W-1:0]                   node_wdata;
  logic                                node_re;
  logic [NA_W-1:0]                     node_raddr;
  logic [NODE_W-1:0]                   node_rdata;
  logic                                feat_we;
  logic                                feat_re;
  logic [VALUE_WIDTH-1:0]              feat_rdata;

  logic [dtl_pkg::FIDX_W-1:0]          node_feat;
  logic signed [VALUE_WIDTH-1:0]       node_thr;
  logic [CW-1:0]                       node_left;
  logic [CW-1:0]                       node_right;
  logic signed [VALUE_WIDTH-1:0]       x_val;
  logic [CW-1:0]                       child;
  logic [ST_W-1:0]                     steps_inc;

  // Split the node entry read back from the table
  assign node_right = node_rdata[CW-1:0];
  assign node_left  = node_rdata[2*CW-1:CW];
  assign node_thr   = node_rdata[2*CW+VALUE_WIDTH-1:2*CW];
  assign node_feat  = node_rdata[NODE_W-1:NODE_W-dtl_pkg::FIDX_W];

  // Compare and pick the child; an absent feature compares zero
  assign x_val     = (int'(node_feat) < MAX_FEATURES) ? feat_rdata : '0;
  assign child     = (x_val < node_thr) ? node_left : node_right;
  assign steps_inc = steps_q + 1'b1;

  // Take a command when idle; a walk also needs the result register free
  assign pop = cmd_valid_i && (state_q == dtl_pkg::WS_IDLE) &&
               ((cmd_i.kind != dtl_pkg::CMD_WALK) || !out_valid_q);
  assign cmd_ready_o = pop;

  // Table writes
  assign node_we    = pop && (cmd_i.kind == dtl_pkg::CMD_NODE) && cmd_i.store;
  assign node_wdata = {cmd_i.split_feature, VALUE_WIDTH'(cmd_i.split_threshold),
                       cmd_i.left_child, cmd_i.right_child};
  assign feat_we    = pop && (cmd_i.kind != dtl_pkg::CMD_NODE) && cmd_i.store;
  assign feat_re    = (state_q == dtl_pkg::WS_NODE);

  // Walk sequencer: next state, reads and result
  always_comb begin
    state_d    = state_q;
    steps_d    = steps_q;
    node_re    = 1'b0;
    node_raddr = '0;
    out_set    = 1'b0;
    out_leaf_d = '0;
    out_err_d  = 1'b0;
    case (state_q)
      dtl_pkg::WS_IDLE: begin
        if (pop && (cmd_i.kind == dtl_pkg::CMD_WALK)) begin
          if (leaf_count_q == '0) begin
            out_set = 1'b1;
          end else begin
            node_re = 1'b1;
            steps_d = '0;
            state_d = dtl_pkg::WS_NODE;
          end
        end
      end
      dtl_pkg::WS_NODE: begin
        state_d = dtl_pkg::WS_FEAT;
      end
      dtl_pkg::WS_FEAT: begin
        steps_d = steps_inc;
        if (child[dtl_pkg::LEAF_BIT]) begin
          out_set    = 1'b1;
          out_leaf_d = child[dtl_pkg::TARGET_W-1:0];
          state_d    = dtl_pkg::WS_IDLE;
        end else if ((int'(child[dtl_pkg::TARGET_W-1:0]) >= MAX_NODES) ||
                     (steps_inc == ST_W'(MAX_NODES))) begin
          out_set   = 1'b1;
          out_err_d = 1'b1;
          state_d   = dtl_pkg::WS_IDLE;
        end else begin
          node_re    = 1'b1;
          node_raddr = NA_W'(child[dtl_pkg::TARGET_W-1:0]);
          state_d    = dtl_pkg::WS_NODE;
        end
      end
      default: begin
        state_d = dtl_pkg::WS_IDLE;
      end
    endcase
  end

  // Sequencer state and step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtl_pkg::WS_IDLE;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      steps_q <= steps_d;
    end
  end

  // Leaf count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= '0;
    end else if (cfg_we_i) begin
      leaf_count_q <= cfg_wdata_i;
    end
  end

  // Result register: hold until the response is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_set) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_set) begin
      out_leaf_q <= out_leaf_d;
      out_err_q  <= out_err_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.leaf_number = out_leaf_q;
  assign rsp_o.walk_error  = out_err_q;

  // Node table: feature index, threshold and both children per entry
  dtl_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES),
    .AW    (NA_W)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (NA_W'(cmd_i.slot)),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  // Feature store
  dtl_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_FEATURES),
    .AW    (FA_W)
  ) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (feat_we),
    .waddr_i (FA_W'(cmd_i.feature_position)),
    .wdata_i (VALUE_WIDTH'(cmd_i.feature_value)),
    .re_i    (feat_re),
    .raddr_i (FA_W'(node_feat)),
    .rdata_o (feat_rdata)
  );

endmodule

// ===== rtl/core/decision_tree_leaf_lookup_top.sv =====
// Top level of the decision tree leaf lookup block.
// Path: a walk request passes the front stage register and the command queue; the back end
//   then reads a node and a feature per level; an empty tree (leaf count zero) reads none.
// Throughput: node writes and feature loads sustain one request per cycle while no walk holds
//   the back end; a walk holds it to the result, a node read and a feature read per level.
// Reset: asynchronous, active low; clears queue, sequencer and leaf count, not the tables.
`timescale 1ns / 1ps

module decision_tree_leaf_lookup_top #(
  parameter int unsigned MAX_NODES    = 1024,
  parameter int unsigned MAX_FEATURES = 256,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dtl_pkg::LEAF_CNT_W-1:0]  cfg_wdata_i,
  dtl_req_if.sink                         req_i,
  dtl_rsp_if.source                       rsp_o
);

  logic          front_valid;
  logic          front_ready;
  dtl_pkg::cmd_t front_cmd;
  logic          queue_valid;
  logic          queue_ready;
  dtl_pkg::cmd_t queue_cmd;

  // Accept and classify requests
  dtl_front #(
    .MAX_NODES    (MAX_NODES),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  // Buffer commands between front and back
  dtl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_cmd_i    (front_cmd),
    .out_valid_o (queue_valid),
    .out_ready_i (queue_ready),
    .out_cmd_o   (queue_cmd)
  );

  // Store entries and walk the tree
  dtl_back #(
    .MAX_NODES    (MAX_NODES),
    .MAX_FEATURES (MAX_FEATURES),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .cmd_i       (queue_cmd),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== rtl/core/dtl_checker.sv =====
// Port level assertions for the decision tree leaf lookup block, with its bind.
`timescale 1ns / 1ps

module dtl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [dtl_pkg::TARGET_W-1:0]  leaf_number_i,
  input logic                          walk_error_i
);

  // Hold a stalled response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(leaf_number_i) && $stable(walk_error_i))
    else $error("stalled response changed");

  // A failed walk reports leaf zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && walk_error_i |-> (leaf_number_i == '0))
    else $error("walk error with nonzero leaf");

  // Two responses never arrive in back to back cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_ready_i |=> !rsp_valid_i)
    else $error("response followed a taken response at once");

  // No response while reset is asserted
  assert property (@(posedge clk_i)
    !rst_ni |-> !rsp_valid_i)
    else $error("response valid during reset");

endmodule

bind decision_tree_leaf_lookup_top dtl_checker u_dtl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .leaf_number_i (rsp_o.leaf_number),
  .walk_error_i  (rsp_o.walk_error)
);
